[src/quadratic_linear_root_solver_assert.svh]
// ---------------------------------------------------------------------------
// quadratic linear root solver assertion macros
// concurrent property macros shared by the checker
// ---------------------------------------------------------------------------
`ifndef QUADRATIC_LINEAR_ROOT_SOLVER_ASSERT_SVH
`define QUADRATIC_LINEAR_ROOT_SOLVER_ASSERT_SVH

// same-cycle implication
`define QLRS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define QLRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/qlrs_pkg.sv]
// ---------------------------------------------------------------------------
// qlrs_pkg
// shared widths, codes and pipeline payload types of the root solver
// ---------------------------------------------------------------------------
package qlrs_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int VAL_W         = 32;
	localparam int LIM_W         = 16;
	localparam int NUM_W         = 36;
	localparam int DEN_W         = 34;
	localparam int RAD_W         = 66;
	localparam int ROOT_W        = RAD_W / 2;
	localparam int SQ_REM_W      = ROOT_W + 3;

	localparam logic [LIM_W-1:0] LIM_RESET = 16'd1;

	// result status codes
	typedef enum logic [1:0] {
		STATUS_NONE = 2'd0,
		STATUS_REAL = 2'd1,
		STATUS_CPLX = 2'd2
	} status_t;

	// kind of work an item carries down the pipe
	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_SINGLE = 2'd1,
		KIND_REAL   = 2'd2,
		KIND_CPLX   = 2'd3
	} kind_t;

	// numerator base and divisor of an item
	typedef struct packed {
		kind_t                   kind;
		logic signed [NUM_W-1:0] n0;
		logic signed [DEN_W-1:0] den;
	} side_t;

	// quotients leaving the divider
	typedef struct packed {
		kind_t                   kind;
		logic signed [VAL_W-1:0] v1;
		logic signed [VAL_W-1:0] v2;
		logic                    sat1;
		logic                    sat2;
	} quot_t;

	function automatic logic [VAL_W-1:0] mag32(input logic signed [VAL_W-1:0] v);
		return v[VAL_W-1] ? (~v + 1'b1) : v;
	endfunction

	function automatic logic signed [NUM_W-1:0] sx_num(input logic signed [VAL_W-1:0] v);
		return {{(NUM_W-VAL_W){v[VAL_W-1]}}, v};
	endfunction

	function automatic logic signed [DEN_W-1:0] sx_den(input logic signed [VAL_W-1:0] v);
		return {{(DEN_W-VAL_W){v[VAL_W-1]}}, v};
	endfunction

endpackage

[src/qlrs_req_if.sv]
// ---------------------------------------------------------------------------
// qlrs_req_if
// coefficient item channel with valid/ready handshake
// ---------------------------------------------------------------------------
interface qlrs_req_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  req_type;
	logic signed [qlrs_pkg::VAL_W-1:0]     coef_a;
	logic signed [qlrs_pkg::VAL_W-1:0]     coef_b;
	logic signed [qlrs_pkg::VAL_W-1:0]     coef_c;

	modport source (output valid, req_type, coef_a, coef_b, coef_c, input ready);
	modport sink (input valid, req_type, coef_a, coef_b, coef_c, output ready);
endinterface

[src/qlrs_res_if.sv]
// ---------------------------------------------------------------------------
// qlrs_res_if
// root result item channel with valid/ready handshake
// ---------------------------------------------------------------------------
interface qlrs_res_if;
	logic                                  valid;
	logic                                  ready;
	logic [1:0]                            status;
	logic signed [qlrs_pkg::VAL_W-1:0]     first_value;
	logic signed [qlrs_pkg::VAL_W-1:0]     second_value;
	logic                                  roots_distinct;
	logic                                  saturated;

	modport source (output valid, status, first_value, second_value, roots_distinct,
		saturated, input ready);
	modport sink (input valid, status, first_value, second_value, roots_distinct,
		saturated, output ready);
endinterface

[src/qlrs_front.sv]
// ---------------------------------------------------------------------------
// qlrs_front
// classifies an item, forms the products and the exact discriminant
// ---------------------------------------------------------------------------
module qlrs_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 in_valid,
	input  logic                                 req_type,
	input  logic signed [qlrs_pkg::VAL_W-1:0]    coef_a,
	input  logic signed [qlrs_pkg::VAL_W-1:0]    coef_b,
	input  logic signed [qlrs_pkg::VAL_W-1:0]    coef_c,
	input  logic [qlrs_pkg::LIM_W-1:0]           limit,
	output logic                                 out_valid,
	output logic [qlrs_pkg::RAD_W-1:0]           out_rad,
	output qlrs_pkg::side_t                      out_side
);

	logic [qlrs_pkg::VAL_W-1:0] a_mag, b_mag, c_mag;
	logic                       a_zero, b_zero;
	qlrs_pkg::side_t            side_d;
	logic [2*qlrs_pkg::VAL_W-1:0] bb_d, p_d;

	logic                         valid_s1;
	qlrs_pkg::side_t              side_s1;
	logic [2*qlrs_pkg::VAL_W-1:0] bb_s1, p_s1;
	logic                         opp_s1;

	logic [qlrs_pkg::RAD_W-1:0]   bb_x, q4_x, rad_d;
	qlrs_pkg::side_t              side2_d;

	// magnitudes and near-zero tests
	assign a_mag  = qlrs_pkg::mag32(coef_a);
	assign b_mag  = qlrs_pkg::mag32(coef_b);
	assign c_mag  = qlrs_pkg::mag32(coef_c);
	assign a_zero = (a_mag == '0) || (a_mag < {{(qlrs_pkg::VAL_W-qlrs_pkg::LIM_W){1'b0}}, limit});
	assign b_zero = (b_mag == '0) || (b_mag < {{(qlrs_pkg::VAL_W-qlrs_pkg::LIM_W){1'b0}}, limit});

	// pick the kind, numerator base and divisor
	always_comb begin
		side_d.kind = qlrs_pkg::KIND_NONE;
		side_d.n0   = '0;
		side_d.den  = qlrs_pkg::sx_den(coef_a);
		if (!req_type) begin
			if (!a_zero) begin
				side_d.kind = qlrs_pkg::KIND_SINGLE;
				side_d.n0   = qlrs_pkg::sx_num(coef_c) - qlrs_pkg::sx_num(coef_b);
			end
		end else if (a_zero) begin
			side_d.den = qlrs_pkg::sx_den(coef_b);
			if (!b_zero) begin
				side_d.kind = qlrs_pkg::KIND_SINGLE;
				side_d.n0   = -qlrs_pkg::sx_num(coef_c);
			end
		end else begin
			side_d.kind = qlrs_pkg::KIND_REAL;
			side_d.n0   = -qlrs_pkg::sx_num(coef_b);
			side_d.den  = qlrs_pkg::sx_den(coef_a) <<< 1;
		end
	end

	// b squared and |a*c|
	assign bb_d = b_mag * b_mag;
	assign p_d  = a_mag * c_mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_d;
			bb_s1   <= bb_d;
			p_s1    <= p_d;
			opp_s1  <= coef_a[qlrs_pkg::VAL_W-1] ^ coef_c[qlrs_pkg::VAL_W-1];
		end
	end

	// discriminant b*b - 4ac as magnitude and sign
	assign bb_x = {2'b00, bb_s1};
	assign q4_x = {p_s1, 2'b00};

	always_comb begin
		side2_d = side_s1;
		rad_d   = '0;
		if (side_s1.kind == qlrs_pkg::KIND_REAL) begin
			if (opp_s1 && (p_s1 != '0)) begin
				rad_d = bb_x + q4_x;
			end else if (q4_x <= bb_x) begin
				rad_d = bb_x - q4_x;
			end else begin
				rad_d        = q4_x - bb_x;
				side2_d.kind = qlrs_pkg::KIND_CPLX;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_rad  <= rad_d;
			out_side <= side2_d;
		end
	end

endmodule

[src/qlrs_sqrt.sv]
// ---------------------------------------------------------------------------
// qlrs_sqrt
// pipelined floor square root, one root bit per register stage
// ---------------------------------------------------------------------------
module qlrs_sqrt (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  logic [qlrs_pkg::RAD_W-1:0]        in_rad,
	input  qlrs_pkg::side_t                   in_side,
	output logic                              out_valid,
	output logic [qlrs_pkg::ROOT_W-1:0]       out_root,
	output qlrs_pkg::side_t                   out_side
);

	localparam int N  = qlrs_pkg::ROOT_W;
	localparam int RW = qlrs_pkg::SQ_REM_W;

	logic                         valid_s [N];
	logic [qlrs_pkg::RAD_W-1:0]   rad_s   [N];
	logic [RW-1:0]                rem_s   [N];
	logic [N-1:0]                 root_s  [N];
	qlrs_pkg::side_t              side_s  [N];

	for (genvar i = 0; i < N; i++) begin : g_stage
		logic                       v_in;
		logic [qlrs_pkg::RAD_W-1:0] rad_in;
		logic [RW-1:0]              rem_in;
		logic [N-1:0]               root_in;
		qlrs_pkg::side_t            side_in;
		logic [RW-1:0]              r2, trial;
		logic                       ge;

		if (i == 0) begin : g_first
			assign v_in    = in_valid;
			assign rad_in  = in_rad;
			assign rem_in  = '0;
			assign root_in = '0;
			assign side_in = in_side;
		end else begin : g_next
			assign v_in    = valid_s[i-1];
			assign rad_in  = rad_s[i-1];
			assign rem_in  = rem_s[i-1];
			assign root_in = root_s[i-1];
			assign side_in = side_s[i-1];
		end

		// bring down two radicand bits, try root*4+1
		assign r2    = {rem_in[RW-3:0], rad_in[qlrs_pkg::RAD_W-1 -: 2]};
		assign trial = {{(RW-N-2){1'b0}}, root_in, 2'b01};
		assign ge    = r2 >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i] <= 1'b0;
			end else if (en) begin
				valid_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[i]  <= {rad_in[qlrs_pkg::RAD_W-3:0], 2'b00};
				rem_s[i]  <= ge ? (r2 - trial) : r2;
				root_s[i] <= {root_in[N-2:0], ge};
				side_s[i] <= side_in;
			end
		end
	end

	assign out_valid = valid_s[N-1];
	assign out_root  = root_s[N-1];
	assign out_side  = side_s[N-1];

endmodule

[src/qlrs_div.sv]
// ---------------------------------------------------------------------------
// qlrs_div
// forms both numerators and divides them in two pipelined lanes,
// one quotient bit per stage, then clamps to the signed value range
// ---------------------------------------------------------------------------
module qlrs_div #(
	parameter int FRAC_BITS = qlrs_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  qlrs_pkg::side_t                   in_side,
	input  logic [qlrs_pkg::ROOT_W-1:0]       in_root,
	output logic                              out_valid,
	output qlrs_pkg::quot_t                   out_quot
);

	localparam int NW = qlrs_pkg::NUM_W + FRAC_BITS;
	localparam int RW = qlrs_pkg::DEN_W;
	localparam int VW = qlrs_pkg::VAL_W;

	typedef struct packed {
		logic [NW-1:0] dvd;
		logic [RW-1:0] rem;
		logic [NW-1:0] quo;
	} lane_t;

	typedef struct packed {
		qlrs_pkg::kind_t kind;
		logic [RW-1:0]   md;
		logic [1:0]      neg;
		lane_t [1:0]     lane;
	} stg_t;

	function automatic lane_t step_lane(input lane_t l, input logic [RW-1:0] md);
		logic [RW:0] r2;
		logic        ge;
		lane_t       o;
		r2    = {l.rem, l.dvd[NW-1]};
		ge    = r2 >= {1'b0, md};
		o.dvd = {l.dvd[NW-2:0], 1'b0};
		o.rem = ge ? RW'(r2 - {1'b0, md}) : RW'(r2);
		o.quo = {l.quo[NW-2:0], ge};
		return o;
	endfunction

	function automatic logic signed [VW-1:0] clamp(input logic [NW-1:0] q, input logic neg,
		output logic sat);
		logic [NW-1:0] lim_neg, lim_pos;
		lim_neg = {{(NW-VW){1'b0}}, 1'b1, {(VW-1){1'b0}}};
		lim_pos = {{(NW-VW+1){1'b0}}, {(VW-1){1'b1}}};
		sat     = 1'b0;
		if (neg) begin
			if (q > lim_neg) begin
				sat = 1'b1;
				return lim_neg[VW-1:0];
			end
			return ~q[VW-1:0] + 1'b1;
		end
		if (q > lim_pos) begin
			sat = 1'b1;
			return lim_pos[VW-1:0];
		end
		return q[VW-1:0];
	endfunction

	logic signed [qlrs_pkg::NUM_W-1:0] root_x, n1, n2;
	logic [qlrs_pkg::NUM_W-1:0]        m1, m2;
	stg_t                              num_d;

	logic  valid_s [NW+1];
	stg_t  stg_s   [NW+1];

	// numerators from -b and the root, by kind
	assign root_x = {{(qlrs_pkg::NUM_W-qlrs_pkg::ROOT_W){1'b0}}, in_root};

	always_comb begin
		case (in_side.kind)
			qlrs_pkg::KIND_REAL: begin
				n1 = in_side.n0 + root_x;
				n2 = in_side.n0 - root_x;
			end
			qlrs_pkg::KIND_CPLX: begin
				n1 = in_side.n0;
				n2 = root_x;
			end
			default: begin
				n1 = in_side.n0;
				n2 = in_side.n0;
			end
		endcase
	end

	// magnitudes, signs and scaled dividends
	assign m1 = n1[qlrs_pkg::NUM_W-1] ? (~n1 + 1'b1) : n1;
	assign m2 = n2[qlrs_pkg::NUM_W-1] ? (~n2 + 1'b1) : n2;

	always_comb begin
		num_d.kind = in_side.kind;
		num_d.md   = in_side.den[RW-1] ? (~in_side.den + 1'b1) : in_side.den;
		num_d.neg  = {n2[qlrs_pkg::NUM_W-1] ^ in_side.den[RW-1],
			n1[qlrs_pkg::NUM_W-1] ^ in_side.den[RW-1]};
		num_d.lane[0].dvd = {m1, {FRAC_BITS{1'b0}}};
		num_d.lane[0].rem = '0;
		num_d.lane[0].quo = '0;
		num_d.lane[1].dvd = {m2, {FRAC_BITS{1'b0}}};
		num_d.lane[1].rem = '0;
		num_d.lane[1].quo = '0;
	end

	// numerator stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else if (en) begin
			valid_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stg_s[0] <= num_d;
		end
	end

	// restoring division stages
	for (genvar i = 1; i <= NW; i++) begin : g_stage
		stg_t nxt;

		always_comb begin
			nxt         = stg_s[i-1];
			nxt.lane[0] = step_lane(stg_s[i-1].lane[0], stg_s[i-1].md);
			nxt.lane[1] = step_lane(stg_s[i-1].lane[1], stg_s[i-1].md);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i] <= 1'b0;
			end else if (en) begin
				valid_s[i] <= valid_s[i-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				stg_s[i] <= nxt;
			end
		end
	end

	// clamp the final quotients
	always_comb begin
		out_quot.kind = stg_s[NW].kind;
		out_quot.v1   = clamp(stg_s[NW].lane[0].quo, stg_s[NW].neg[0], out_quot.sat1);
		out_quot.v2   = clamp(stg_s[NW].lane[1].quo, stg_s[NW].neg[1], out_quot.sat2);
	end

	assign out_valid = valid_s[NW];

endmodule

[src/quadratic_linear_root_solver.sv]
// throughput: one item per cycle; the whole pipe advances when the output register is free
// the pipe is 2 front stages, 33 square-root stages, a numerator stage,
// 36 + FRAC_BITS divider stages and the output register
// reset clears every valid bit and sets near_zero_limit to 1
// ---------------------------------------------------------------------------
// quadratic_linear_root_solver
// fixed-point linear and quadratic root solver, fully pipelined
// ---------------------------------------------------------------------------
module quadratic_linear_root_solver #(
	parameter int FRAC_BITS = qlrs_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [qlrs_pkg::LIM_W-1:0]    cfg_wdata,
	qlrs_req_if.sink                      req,
	qlrs_res_if.source                    res
);

	logic                           en;
	logic [qlrs_pkg::LIM_W-1:0]     limit_q;

	logic                           fr_valid;
	logic [qlrs_pkg::RAD_W-1:0]     fr_rad;
	qlrs_pkg::side_t                fr_side;

	logic                           sq_valid;
	logic [qlrs_pkg::ROOT_W-1:0]    sq_root;
	qlrs_pkg::side_t                sq_side;

	logic                           dv_valid;
	qlrs_pkg::quot_t                dv_quot;

	logic                           out_valid_q;
	logic [1:0]                     status_q;
	logic signed [qlrs_pkg::VAL_W-1:0] first_q, second_q;
	logic                           distinct_q, sat_q;

	logic [1:0]                     status_d;
	logic signed [qlrs_pkg::VAL_W-1:0] first_d, second_d;
	logic                           distinct_d, sat_d;

	// pipe advances whenever the output register can take an item
	assign en        = !out_valid_q || res.ready;
	assign req.ready = en;

	// near-zero limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= qlrs_pkg::LIM_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	qlrs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (req.valid),
		.req_type  (req.req_type),
		.coef_a    (req.coef_a),
		.coef_b    (req.coef_b),
		.coef_c    (req.coef_c),
		.limit     (limit_q),
		.out_valid (fr_valid),
		.out_rad   (fr_rad),
		.out_side  (fr_side)
	);

	qlrs_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (fr_valid),
		.in_rad    (fr_rad),
		.in_side   (fr_side),
		.out_valid (sq_valid),
		.out_root  (sq_root),
		.out_side  (sq_side)
	);

	qlrs_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_valid),
		.in_side   (sq_side),
		.in_root   (sq_root),
		.out_valid (dv_valid),
		.out_quot  (dv_quot)
	);

	// result fields by kind
	always_comb begin
		status_d   = qlrs_pkg::STATUS_NONE;
		first_d    = '0;
		second_d   = '0;
		distinct_d = 1'b0;
		sat_d      = 1'b0;
		case (dv_quot.kind)
			qlrs_pkg::KIND_SINGLE: begin
				status_d = qlrs_pkg::STATUS_REAL;
				first_d  = dv_quot.v1;
				second_d = dv_quot.v1;
				sat_d    = dv_quot.sat1;
			end
			qlrs_pkg::KIND_REAL: begin
				status_d   = qlrs_pkg::STATUS_REAL;
				first_d    = dv_quot.v1;
				second_d   = dv_quot.v2;
				distinct_d = dv_quot.v1 != dv_quot.v2;
				sat_d      = dv_quot.sat1 | dv_quot.sat2;
			end
			qlrs_pkg::KIND_CPLX: begin
				status_d = qlrs_pkg::STATUS_CPLX;
				first_d  = dv_quot.v1;
				second_d = dv_quot.v2;
				sat_d    = dv_quot.sat1 | dv_quot.sat2;
			end
			default: begin
				status_d = qlrs_pkg::STATUS_NONE;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			status_q   <= status_d;
			first_q    <= first_d;
			second_q   <= second_d;
			distinct_q <= distinct_d;
			sat_q      <= sat_d;
		end
	end

	assign res.valid          = out_valid_q;
	assign res.status         = status_q;
	assign res.first_value    = first_q;
	assign res.second_value   = second_q;
	assign res.roots_distinct = distinct_q;
	assign res.saturated      = sat_q;

endmodule

[src/qlrs_checker.sv]
// ---------------------------------------------------------------------------
// qlrs_checker
// port-level properties of the root solver result channel
// ---------------------------------------------------------------------------
`include "quadratic_linear_root_solver_assert.svh"

module qlrs_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              res_valid,
	input logic                              res_ready,
	input logic [1:0]                        status,
	input logic signed [qlrs_pkg::VAL_W-1:0] first_value,
	input logic signed [qlrs_pkg::VAL_W-1:0] second_value,
	input logic                              roots_distinct,
	input logic                              saturated
);

	// status is always a defined code
	`QLRS_ASSERT_NOW(a_status_code, clk, arst_n, res_valid, (status == qlrs_pkg::STATUS_NONE || status == qlrs_pkg::STATUS_REAL || status == qlrs_pkg::STATUS_CPLX), "undefined status code")

	// distinct roots only for a real pair
	`QLRS_ASSERT_NOW(a_distinct_real, clk, arst_n, res_valid && roots_distinct, status == qlrs_pkg::STATUS_REAL, "roots_distinct without real roots")

	// no solution carries zero values and a clear saturated flag
	`QLRS_ASSERT_NOW(a_none_zero, clk, arst_n, res_valid && status == qlrs_pkg::STATUS_NONE, (first_value == '0 && second_value == '0 && !saturated), "no-solution item has nonzero fields")

	// a stalled item stays valid and holds its first value and status
	`QLRS_ASSERT_NEXT(a_stall_hold, clk, arst_n, res_valid && !res_ready, (res_valid && $stable(first_value) && $stable(status)), "stalled result item changed")

endmodule

bind quadratic_linear_root_solver qlrs_checker u_qlrs_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (res.valid),
	.res_ready      (res.ready),
	.status         (res.status),
	.first_value    (res.first_value),
	.second_value   (res.second_value),
	.roots_distinct (res.roots_distinct),
	.saturated      (res.saturated)
);
